FILE: sv/identification_frame_encoder_macros.svh
// Assertion macros used by the identification frame encoder checker.
`ifndef IDENTIFICATION_FRAME_ENCODER_MACROS_SVH
`define IDENTIFICATION_FRAME_ENCODER_MACROS_SVH

// Check a property at every rising edge outside reset.
`define IFE_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition in one cycle brings a consequence in the next.
`define IFE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/ife_pkg.sv
// Types, constants and parity table of the identification frame encoder.
`default_nettype none
package ife_pkg;

	localparam int ADDR_BITS   = 24;
	localparam int CALL_CHARS  = 8;
	localparam int CODE_BITS   = 6;
	localparam int CALL_BITS   = CALL_CHARS * CODE_BITS;
	localparam int HDR_BITS    = 40;
	localparam int DATA_BITS   = HDR_BITS + CALL_BITS;
	localparam int PAR_BITS    = 24;
	localparam int FRAME_BITS  = DATA_BITS + PAR_BITS;
	localparam int FRAME_BYTES = FRAME_BITS / 8;
	localparam int POS_BITS    = 4;

	localparam logic [PAR_BITS-1:0] PAR_POLY   = 24'hFFF409;
	localparam logic [4:0]          DF_CODE    = 5'd17;
	localparam logic [2:0]          CAPABILITY = 3'd5;
	localparam logic [4:0]          TYPE_CODE  = 5'd4;
	localparam logic [2:0]          EMIT_CAT   = 3'd0;
	localparam logic [7:0]          HDR_BYTE0  = {DF_CODE, CAPABILITY};
	localparam logic [7:0]          HDR_BYTE4  = {TYPE_CODE, EMIT_CAT};
	localparam logic [3:0]          MAX_LEN    = 4'(CALL_CHARS);
	localparam logic [POS_BITS-1:0] LAST_POS   = POS_BITS'(FRAME_BYTES - 1);

	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_A     = 8'h41;
	localparam logic [7:0] CH_Z     = 8'h5A;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_BAD_ADDR = 2'd1,
		ST_BAD_CALL = 2'd2
	} status_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] code;
		logic                 bad;
		logic [PAR_BITS-1:0]  par;
	} lane_res_t;

	typedef struct packed {
		logic [FRAME_BITS-1:0] bits;
		status_t               status;
	} frame_t;

	typedef logic [DATA_BITS-1:0][PAR_BITS-1:0] par_tbl_t;

	// Parity of a message with only one data bit set, for each bit position.
	function automatic par_tbl_t build_par_tbl();
		par_tbl_t            tbl;
		logic [PAR_BITS-1:0] r;
		logic                top;
		for (int i = 0; i < DATA_BITS; i++) begin
			r = '0;
			for (int j = 0; j < DATA_BITS; j++) begin
				top = r[PAR_BITS-1];
				r = {r[PAR_BITS-2:0], 1'b0};
				if (top ^ (j == i)) begin
					r = r ^ PAR_POLY;
				end
			end
			tbl[i] = r;
		end
		return tbl;
	endfunction

	localparam par_tbl_t PAR_TBL = build_par_tbl();

	function automatic logic char_bad(input logic [7:0] ch);
		logic ok;
		ok = ((ch >= CH_A) && (ch <= CH_Z)) || ((ch >= CH_0) && (ch <= CH_9))
			|| (ch == CH_SPACE);
		return !ok;
	endfunction

endpackage
`default_nettype wire

FILE: sv/ife_in_if.sv
// Request channel carrying address and callsign into the encoder.
`default_nettype none
interface ife_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] aircraft_address;
	logic [63:0] callsign_text;
	logic [3:0]  callsign_length;

	modport source (output valid, aircraft_address, callsign_text, callsign_length,
		input ready);
	modport sink (input valid, aircraft_address, callsign_text, callsign_length,
		output ready);
endinterface
`default_nettype wire

FILE: sv/ife_out_if.sv
// Byte channel carrying encoded frame bytes out of the encoder.
`default_nettype none
interface ife_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic [3:0] byte_position;
	logic       is_last;
	logic [1:0] status;

	modport source (output valid, frame_byte, byte_position, is_last, status,
		input ready);
	modport sink (input valid, frame_byte, byte_position, is_last, status,
		output ready);
endinterface
`default_nettype wire

FILE: sv/ife_lane.sv
// One character lane: code, validity and parity share of one callsign character.
`default_nettype none
module ife_lane #(
	parameter int LANE_IDX = 0
) (
	input  wire logic              clk,
	input  wire logic              en,
	input  wire logic [7:0]        ch,
	input  wire logic              in_use,
	output ife_pkg::lane_res_t     res_s1
);
	localparam int BIT_BASE = ife_pkg::HDR_BITS + LANE_IDX * ife_pkg::CODE_BITS;

	logic [7:0]                        ch_eff;
	logic [ife_pkg::CODE_BITS-1:0]     code;
	logic [ife_pkg::PAR_BITS-1:0]      par;

	always_comb begin
		ch_eff = in_use ? ch : ife_pkg::CH_SPACE;
		code = ch_eff[ife_pkg::CODE_BITS-1:0];
		par = '0;
		for (int b = 0; b < ife_pkg::CODE_BITS; b++) begin
			if (code[ife_pkg::CODE_BITS-1-b]) begin
				par = par ^ ife_pkg::PAR_TBL[BIT_BASE + b];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s1.code <= code;
			res_s1.bad  <= ife_pkg::char_bad(ch_eff);
			res_s1.par  <= par;
		end
	end
endmodule
`default_nettype wire

FILE: sv/ife_merge.sv
// Merge stage: combine lane results with the header into a frame or an error.
`default_nettype none
module ife_merge (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	input  wire logic                                       valid_s1,
	input  wire logic [ife_pkg::ADDR_BITS-1:0]              addr_s1,
	input  wire logic                                       addr_bad_s1,
	input  wire logic                                       len_bad_s1,
	input  wire ife_pkg::lane_res_t [ife_pkg::CALL_CHARS-1:0] lanes_s1,
	input  wire logic                                       take,
	output logic                                            ready,
	output logic                                            valid_s2,
	output ife_pkg::frame_t                                 frame_s2
);
	logic [ife_pkg::HDR_BITS-1:0]  hdr;
	logic [ife_pkg::CALL_BITS-1:0] codes;
	logic [ife_pkg::PAR_BITS-1:0]  par;
	logic                          call_bad;
	ife_pkg::frame_t               frame_d;

	assign ready = !valid_s2 || take;

	always_comb begin
		hdr = {ife_pkg::HDR_BYTE0, addr_s1, ife_pkg::HDR_BYTE4};
		par = '0;
		for (int i = 0; i < ife_pkg::HDR_BITS; i++) begin
			if (hdr[ife_pkg::HDR_BITS-1-i]) begin
				par = par ^ ife_pkg::PAR_TBL[i];
			end
		end
		call_bad = len_bad_s1;
		codes = '0;
		for (int k = 0; k < ife_pkg::CALL_CHARS; k++) begin
			codes[ife_pkg::CALL_BITS-1-k*ife_pkg::CODE_BITS -: ife_pkg::CODE_BITS] =
				lanes_s1[k].code;
			par = par ^ lanes_s1[k].par;
			call_bad = call_bad || lanes_s1[k].bad;
		end
		priority if (addr_bad_s1) begin
			frame_d.bits   = '0;
			frame_d.status = ife_pkg::ST_BAD_ADDR;
		end else if (call_bad) begin
			frame_d.bits   = '0;
			frame_d.status = ife_pkg::ST_BAD_CALL;
		end else begin
			frame_d.bits   = {hdr, codes, par};
			frame_d.status = ife_pkg::ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready && valid_s1) begin
			frame_s2 <= frame_d;
		end
	end
endmodule
`default_nettype wire

FILE: sv/ife_ser.sv
// Serializer: send a held frame one byte per request, or a single error request.
`default_nettype none
module ife_ser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        valid_s2,
	input  wire ife_pkg::frame_t frame_s2,
	output logic             take,
	ife_out_if.source        result
);
	logic                                busy_q;
	logic [ife_pkg::POS_BITS-1:0]        pos_q;
	logic [ife_pkg::FRAME_BITS-1:0]      bits_q;
	ife_pkg::status_t                    status_q;
	logic                                last;
	logic                                sent;

	assign last = (status_q != ife_pkg::ST_OK) || (pos_q == ife_pkg::LAST_POS);
	assign sent = busy_q && result.ready;
	assign take = valid_s2 && (!busy_q || (sent && last));

	assign result.valid         = busy_q;
	assign result.frame_byte    = bits_q[ife_pkg::FRAME_BITS-1 -: 8];
	assign result.byte_position = pos_q;
	assign result.is_last       = last;
	assign result.status        = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (take) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (sent) begin
			busy_q <= !last;
			pos_q  <= pos_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			bits_q   <= frame_s2.bits;
			status_q <= frame_s2.status;
		end else if (sent) begin
			bits_q <= {bits_q[ife_pkg::FRAME_BITS-9:0], 8'h00};
		end
	end
endmodule
`default_nettype wire

FILE: sv/identification_frame_encoder.sv
// Identification frame encoder: eight character lanes, merge stage, byte serializer.
// A request accepted into the lane registers passes the merge register before the
// serializer sends its first byte. The one-byte result port sets throughput: a frame
// goes out as 14 bytes, an error request as one result. Lanes and merge stage take
// a new request while the serializer still sends, so frames follow with no gap.
// Reset (arst_n low) clears all valid flags and the byte counter at once.
`default_nettype none
module identification_frame_encoder (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ife_in_if.sink     item,
	ife_out_if.source  result
);
	logic                                             valid_s1;
	logic                                             en1;
	logic                                             load1;
	logic [ife_pkg::ADDR_BITS-1:0]                    addr_s1;
	logic                                             addr_bad_s1;
	logic                                             len_bad_s1;
	ife_pkg::lane_res_t [ife_pkg::CALL_CHARS-1:0]     lanes_s1;
	logic                                             merge_ready;
	logic                                             valid_s2;
	ife_pkg::frame_t                                  frame_s2;
	logic                                             take;

	assign en1        = !valid_s1 || merge_ready;
	assign item.ready = en1;
	assign load1      = item.valid && en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load1) begin
			addr_s1     <= item.aircraft_address[ife_pkg::ADDR_BITS-1:0];
			addr_bad_s1 <= |item.aircraft_address[31:ife_pkg::ADDR_BITS];
			len_bad_s1  <= item.callsign_length > ife_pkg::MAX_LEN;
		end
	end

	for (genvar k = 0; k < ife_pkg::CALL_CHARS; k++) begin : g_lane
		ife_lane #(
			.LANE_IDX(k)
		) u_lane (
			.clk    (clk),
			.en     (load1),
			.ch     (item.callsign_text[63-8*k -: 8]),
			.in_use (item.callsign_length > 4'(k)),
			.res_s1 (lanes_s1[k])
		);
	end

	ife_merge u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.valid_s1    (valid_s1),
		.addr_s1     (addr_s1),
		.addr_bad_s1 (addr_bad_s1),
		.len_bad_s1  (len_bad_s1),
		.lanes_s1    (lanes_s1),
		.take        (take),
		.ready       (merge_ready),
		.valid_s2    (valid_s2),
		.frame_s2    (frame_s2)
	);

	ife_ser u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s2 (valid_s2),
		.frame_s2 (frame_s2),
		.take     (take),
		.result   (result)
	);
endmodule
`default_nettype wire

FILE: sv/ife_checker.sv
// Port checker for the identification frame encoder and its bind.
`default_nettype none
`include "identification_frame_encoder_macros.svh"
module ife_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] frame_byte,
	input wire logic [3:0] byte_position,
	input wire logic       is_last,
	input wire logic [1:0] status
);
	logic [14:0] res_word;

	assign res_word = {frame_byte, byte_position, is_last, status};

	`IFE_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(res_word), "stalled result changed")
	`IFE_ASSERT(a_error, clk, arst_n,
		out_valid && (status != ife_pkg::ST_OK) |->
		(frame_byte == 8'd0) && (byte_position == 4'd0) && is_last,
		"malformed error result")
	`IFE_ASSERT_NEXT(a_seq, clk, arst_n, out_valid && out_ready && !is_last,
		out_valid && (byte_position == $past(byte_position) + 4'd1)
		&& (status == ife_pkg::ST_OK),
		"frame byte missing or out of order")
	`IFE_ASSERT(a_last, clk, arst_n,
		out_valid && (status == ife_pkg::ST_OK) |->
		(is_last == (byte_position == ife_pkg::LAST_POS)),
		"frame end at wrong byte")
endmodule

bind identification_frame_encoder ife_checker u_ife_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (result.valid),
	.out_ready     (result.ready),
	.frame_byte    (result.frame_byte),
	.byte_position (result.byte_position),
	.is_last       (result.is_last),
	.status        (result.status)
);
`default_nettype wire
